### design/assert_macros.svh
// Assertion macros for the history ring RTL.
// Included by files that carry concurrent checks; expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge, off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Check that a condition never holds, off while reset is asserted.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

### design/ohr_pkg.sv
// Package for the overwrite history ring: field widths, request codes, entry type.
// No dependencies.
`timescale 1ns / 1ps

package ohr_pkg;

	localparam int STAMP_W  = 64;
	localparam int SAMPLE_W = 32;

	typedef logic [1:0]          req_type_t;
	typedef logic [STAMP_W-1:0]  stamp_t;
	typedef logic [SAMPLE_W-1:0] sample_t;

	localparam req_type_t REQ_WRITE    = 2'd0;
	localparam req_type_t REQ_READ_NEW = 2'd1;
	localparam req_type_t REQ_READ_ALL = 2'd2;

	typedef struct packed {
		stamp_t  stamp;
		sample_t sample;
	} entry_t;

endpackage

### design/ohr_if.sv
// Valid/ready channel interfaces for requests and emitted entries.
// Depends on ohr_pkg.
`timescale 1ns / 1ps

interface ohr_req_if;
	import ohr_pkg::*;

	logic      valid;
	logic      ready;
	req_type_t req_type;
	stamp_t    stamp_in;
	sample_t   sample_in;

	modport source (output valid, output req_type, output stamp_in, output sample_in,
		input ready);
	modport sink (input valid, input req_type, input stamp_in, input sample_in,
		output ready);
endinterface

interface ohr_rsp_if;
	import ohr_pkg::*;

	logic    valid;
	logic    ready;
	stamp_t  stamp_out;
	sample_t sample_out;
	logic    last_entry;

	modport source (output valid, output stamp_out, output sample_out, output last_entry,
		input ready);
	modport sink (input valid, input stamp_out, input sample_out, input last_entry,
		output ready);
endinterface

### design/ohr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module ohr_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### design/overwrite_ring_history.sv
// Top level of the overwrite-oldest sample history ring.
// Depends on ohr_pkg, ohr_req_if / ohr_rsp_if, ohr_ram and assert_macros.svh.
//
//  channel | dir | fields                                  | notes
//  --------+-----+-----------------------------------------+----------------------------
//  req     | in  | req_type, stamp_in, sample_in           | write / read-new / read-all
//  rsp     | out | stamp_out, sample_out, last_entry       | one item per emitted entry
//
// Flow: writes go back to back. A read is accepted and then streams N entries,
// one per cycle while rsp is ready (N = unread count, or DEPTH for read-all),
// paced by the single RAM read port.
// Reset: pointers and a per-slot valid vector clear at once; no sweep of the
// RAM is needed, an unwritten slot reads back as zero through its valid bit.
// Stalls: while rsp is held off the RAM output register holds and the sweep
// pauses; the next request is taken once the final read has been issued.
`timescale 1ns / 1ps

module overwrite_ring_history #(
	parameter int DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	ohr_req_if.sink   req,
	ohr_rsp_if.source rsp
);
	import ohr_pkg::*;

	`include "assert_macros.svh"

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

	// sequencer states
	localparam logic S_IDLE = 1'b0;
	localparam logic S_RUN  = 1'b1;

	function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
		return (p == LAST_SLOT) ? '0 : p + AW'(1);
	endfunction

	logic              state_q;
	logic [AW-1:0]     wp_q;
	logic [AW-1:0]     rp_q;
	logic [AW-1:0]     pos_q;       // next slot to read during a run
	logic [DEPTH-1:0]  vld_q;       // slot written since reset

	logic              out_valid_s1;
	logic              vld_s1;
	logic              last_s1;

	logic              accept;
	logic              wr_en;
	logic              issue;
	logic              issue_last;
	logic [AW-1:0]     wp_nxt;
	logic [AW-1:0]     pos_nxt;
	entry_t            wr_entry;
	entry_t            rd_entry;

	assign req.ready  = (state_q == S_IDLE);
	assign accept     = req.valid && req.ready;
	assign wr_en      = accept && (req.req_type == REQ_WRITE);
	assign wp_nxt     = next_slot(wp_q);

	// read one slot per cycle while the output register is free or draining
	assign issue      = (state_q == S_RUN) && (!out_valid_s1 || rsp.ready);
	assign pos_nxt    = next_slot(pos_q);
	assign issue_last = (pos_nxt == wp_q);

	assign wr_entry.stamp  = req.stamp_in;
	assign wr_entry.sample = req.sample_in;

	ohr_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wp_q),
		.wdata (wr_entry),
		.re    (issue),
		.raddr (pos_q),
		.rdata (rd_entry)
	);

	// pointers, valid vector and run sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wp_q    <= '0;
			rp_q    <= '0;
			pos_q   <= '0;
			vld_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.req_type)
							REQ_WRITE: begin
								vld_q[wp_q] <= 1'b1;
								wp_q        <= wp_nxt;
								// catching up with the reader drops the oldest unread
								if (wp_nxt == rp_q) begin
									rp_q <= next_slot(wp_nxt);
								end
							end
							REQ_READ_NEW: begin
								if (rp_q != wp_q) begin
									pos_q   <= rp_q;
									rp_q    <= wp_q;
									state_q <= S_RUN;
								end
							end
							REQ_READ_ALL: begin
								pos_q   <= wp_q;
								rp_q    <= wp_q;
								state_q <= S_RUN;
							end
							default: begin
							end
						endcase
					end
				end
				S_RUN: begin
					if (issue) begin
						pos_q <= pos_nxt;
						if (issue_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output stage, aligned with the RAM read register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s1 <= 1'b0;
		end else if (issue) begin
			out_valid_s1 <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			vld_s1  <= vld_q[pos_q];
			last_s1 <= issue_last;
		end
	end

	assign rsp.valid      = out_valid_s1;
	assign rsp.stamp_out  = vld_s1 ? rd_entry.stamp  : '0;
	assign rsp.sample_out = vld_s1 ? rd_entry.sample : '0;
	assign rsp.last_entry = last_s1;

	// checks
	`ASSERT_CLK(a_issue_fills_out, issue |=> out_valid_s1,
		"read issued but output stage not filled")
	`ASSERT_CLK(a_last_ends_run, (issue && issue_last) |=> (state_q == S_IDLE),
		"run did not end after final slot")
	`ASSERT_CLK(a_write_keeps_gap, $past(wr_en) |-> (rp_q != wp_q),
		"write left read pointer equal to write pointer")
	`ASSERT_NEVER(a_pos_range, (state_q == S_RUN) && (pos_q > LAST_SLOT),
		"run position beyond last slot")

endmodule

### bench/overwrite_ring_history_tb.sv
// Self-checking bench for overwrite_ring_history: random and directed requests, scoreboarded entries.
// Depends on ohr_pkg, ohr_req_if / ohr_rsp_if and the overwrite_ring_history RTL.
`timescale 1ns / 1ps

module overwrite_ring_history_tb;
	import ohr_pkg::*;

	localparam int RING_DEPTH = 64;
	// Code 3 has no name in the package; the block must ignore it.
	localparam req_type_t REQ_UNUSED = 2'd3;
	localparam int unsigned ITEM_TARGET = 410;
	localparam int unsigned HOLDOFF_CYCLES = 400;
	// Cycles to wait after the last expected entry, so a stray entry still shows up.
	localparam int unsigned DRAIN_CYCLES = 100;

	// One expected read entry.
	typedef struct {
		stamp_t  stamp;
		sample_t sample;
		logic    last;
	} ring_entry_t;

	// Mirror of the ring: same stores and pointers, and a queue of entries the
	// block still owes us.
	class ring_scoreboard;
		stamp_t      stamp_mem[RING_DEPTH];
		sample_t     sample_mem[RING_DEPTH];
		int unsigned wr_slot;
		int unsigned rd_slot;
		ring_entry_t pending[$];
		int unsigned mismatches;
		int unsigned checked;
		int unsigned writes;
		int unsigned reads;
		int unsigned overruns;

		function new();
			foreach (stamp_mem[i]) begin
				stamp_mem[i]  = '0;
				sample_mem[i] = '0;
			end
			wr_slot    = 0;
			rd_slot    = 0;
			mismatches = 0;
			checked    = 0;
			writes     = 0;
			reads      = 0;
			overruns   = 0;
		endfunction

		function int unsigned next_slot(int unsigned s);
			return (s + 1 >= RING_DEPTH) ? 0 : s + 1;
		endfunction

		// Queue a run of entries from start up to the write slot, at most a full ring.
		function void emit_from(int unsigned start);
			int unsigned pos;
			int unsigned nxt;
			int unsigned count;
			ring_entry_t e;
			pos   = start;
			count = 0;
			do begin
				nxt      = next_slot(pos);
				e.stamp  = stamp_mem[pos];
				e.sample = sample_mem[pos];
				e.last   = (nxt == wr_slot);
				count++;
				if (count >= RING_DEPTH)
					e.last = 1'b1;
				pending.push_back(e);
				pos = nxt;
			end while (pos != wr_slot && count < RING_DEPTH);
			rd_slot = wr_slot;
		endfunction

		function void note_request(req_type_t kind, stamp_t st, sample_t sa);
			case (kind)
				REQ_WRITE: begin
					writes++;
					stamp_mem[wr_slot]  = st;
					sample_mem[wr_slot] = sa;
					wr_slot = next_slot(wr_slot);
					// caught up with the reader: oldest unread entry is dropped
					if (wr_slot == rd_slot) begin
						rd_slot = next_slot(wr_slot);
						overruns++;
					end
				end
				REQ_READ_NEW: begin
					reads++;
					if (rd_slot != wr_slot)
						emit_from(rd_slot);
				end
				REQ_READ_ALL: begin
					reads++;
					emit_from(wr_slot);
				end
				default: ;
			endcase
		endfunction

		function void check_entry(stamp_t st, sample_t sa, logic last);
			ring_entry_t e;
			if (pending.size() == 0) begin
				$error("entry with none expected: stamp %h sample %h last %b", st, sa, last);
				mismatches++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (st !== e.stamp) begin
				$error("stamp_out: expected %h, got %h", e.stamp, st);
				mismatches++;
			end
			if (sa !== e.sample) begin
				$error("sample_out: expected %h, got %h", e.sample, sa);
				mismatches++;
			end
			if (last !== e.last) begin
				$error("last_entry: expected %b, got %b", e.last, last);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ohr_req_if req_ch();
	ohr_rsp_if rsp_ch();

	overwrite_ring_history #(
		.DEPTH(RING_DEPTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	ring_scoreboard ring = new();

	int unsigned send_idle_pct = 0;
	int unsigned rsp_stall_pct = 0;
	int unsigned holdoff_trigger = 0;
	int unsigned sent_items = 0;
	int unsigned ignored_items = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Both channels sampled on the same edge; an entry never shares an edge
	// with the request that caused it, so the order here is harmless.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready)
				ring.check_entry(rsp_ch.stamp_out, rsp_ch.sample_out, rsp_ch.last_entry);
			if (req_ch.valid && req_ch.ready)
				ring.note_request(req_ch.req_type, req_ch.stamp_in, req_ch.sample_in);
		end
	end

	// Receiver pacing. A bump of holdoff_trigger starts a long stall, counted here.
	initial begin : rsp_pacer
		int unsigned hold_left;
		int unsigned seen_trigger;
		hold_left    = 0;
		seen_trigger = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holdoff_trigger != seen_trigger) begin
				seen_trigger = holdoff_trigger;
				hold_left    = HOLDOFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
			end
		end
	end

	function automatic stamp_t rand_stamp();
		return {$urandom, $urandom};
	endfunction

	// Offer one item, after a random gap, and return at the edge it is taken.
	// valid is only lowered when a gap follows, never lowered and raised in one step.
	task automatic send_request(input req_type_t kind, input stamp_t st, input sample_t sa);
		int unsigned gap;
		gap = 0;
		while (gap < 64 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.req_type  <= kind;
		req_ch.stamp_in  <= st;
		req_ch.sample_in <= sa;
		do @(posedge clk); while (!req_ch.ready);
		if (kind == REQ_UNUSED)
			ignored_items++;
		else
			sent_items++;
	endtask

	task automatic write_burst(input int unsigned n);
		repeat (n) send_request(REQ_WRITE, rand_stamp(), $urandom);
	endtask

	task automatic read_new();
		send_request(REQ_READ_NEW, rand_stamp(), $urandom);
	endtask

	task automatic read_all();
		send_request(REQ_READ_ALL, rand_stamp(), $urandom);
	endtask

	// Mostly write bursts closed by a read; some lone reads, noise and
	// unterminated bursts; now and then a burst around a full ring.
	task automatic random_sequence();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 45) begin
			write_burst($urandom_range(1, 10));
			read_new();
		end else if (pick < 55) begin
			write_burst($urandom_range(1, 6));
			read_all();
		end else if (pick < 58) begin
			write_burst($urandom_range(RING_DEPTH - 2, RING_DEPTH + 2));
			if ($urandom_range(1))
				read_new();
			else
				read_all();
		end else if (pick < 68) begin
			read_new();
		end else if (pick < 78) begin
			send_request(REQ_UNUSED, rand_stamp(), $urandom);
			write_burst(1);
		end else if (pick < 86) begin
			read_all();
		end else begin
			write_burst($urandom_range(1, 20));
		end
	endtask

	task automatic set_pacing(input int unsigned idle_pct, input int unsigned stall_pct);
		send_idle_pct = idle_pct;
		rsp_stall_pct <= stall_pct;
	endtask

	initial begin : main
		int unsigned phase_idle[4];
		int unsigned phase_stall[4];
		bit ok;
		phase_idle  = '{0, 88, 0, 14};
		phase_stall = '{0, 0, 88, 14};

		req_ch.valid     <= 1'b0;
		req_ch.req_type  <= REQ_WRITE;
		req_ch.stamp_in  <= '0;
		req_ch.sample_in <= '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: empty ring, never-written slots, ignored code, field extremes,
		// single-entry run, reads after a read.
		set_pacing(0, 0);
		read_new();
		read_all();
		send_request(REQ_UNUSED, '1, '1);
		send_request(REQ_WRITE, '1, '1);
		send_request(REQ_WRITE, '0, '0);
		send_request(REQ_WRITE, 64'h8000_0000_0000_0001, 32'h8000_0001);
		send_request(REQ_WRITE, 64'h5555_5555_5555_5555, 32'haaaa_aaaa);
		send_request(REQ_WRITE, 64'haaaa_aaaa_aaaa_aaaa, 32'h5555_5555);
		read_new();
		read_new();
		send_request(REQ_UNUSED, rand_stamp(), $urandom);
		write_burst(2);
		read_all();
		read_new();
		write_burst(1);
		read_new();
		send_request(REQ_READ_NEW, '1, '1);
		send_request(REQ_READ_ALL, '0, '0);

		// Receiver holds off while requests keep coming: the ring stalls
		// its input behind the pending read-all, then a full ring follows.
		holdoff_trigger <= holdoff_trigger + 1;
		write_burst(3);
		read_all();
		read_new();
		write_burst(RING_DEPTH + 2);
		read_new();
		read_all();

		for (int p = 0; p < 4; p++) begin
			set_pacing(phase_idle[p], phase_stall[p]);
			while (sent_items < ITEM_TARGET * (p + 1) / 4)
				random_sequence();
		end

		req_ch.valid <= 1'b0;
		set_pacing(0, 0);
		while (ring.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		ok = (ring.mismatches == 0) && (ring.pending.size() == 0);
		$display("covered %0d requests: %0d writes, %0d reads, %0d ignored codes",
			sent_items + ignored_items, ring.writes, ring.reads, ignored_items);
		$display("checked %0d entries; %0d writes overran unread entries",
			ring.checked, ring.overruns);
		if (ok)
			$display("overwrite_ring_history regression: pass");
		else
			$display("overwrite_ring_history regression: fail");
		$finish;
	end

	// Far beyond the slowest legal run: every read a full ring under the worst stall.
	initial begin : watchdog
		#20_000_000;
		$display("overwrite_ring_history regression: fail");
		$finish;
	end

endmodule
